/* hdl/base64_stream_codec_top_defines.svh */
// Assertion macros shared by the base64 stream codec modules
`ifndef BASE64_STREAM_CODEC_TOP_DEFINES_SVH
`define BASE64_STREAM_CODEC_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define B64_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("b64 invariant violated");

// Check that an antecedent implies a consequent in the same cycle
`define B64_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b64 implication violated");

// Check that an antecedent implies a consequent in the next cycle
`define B64_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64 next-cycle check violated");

`endif

/* hdl/b64_pkg.sv */
// Package: types, constants and character functions of the base64 stream codec
`default_nettype none
package b64_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_DIRECTION = 2'd0;
   localparam logic [1:0] CSR_URL_SAFE  = 2'd1;

   // Direction register values
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // Job queue sizing
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Alphabet section boundaries
   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_PLUS       = 6'd62;
   localparam logic [5:0] SEXTET_SLASH      = 6'd63;

   // Characters
   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;
   localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHR_PLUS    = 8'h2B;
   localparam logic [7:0] CHR_SLASH   = 8'h2F;
   localparam logic [7:0] CHR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHR_MINUS   = 8'h2D;
   localparam logic [7:0] CHR_UNDER   = 8'h5F;
   localparam logic [7:0] CHR_DOT     = 8'h2E;

   // Flag for an invalid character in the sextet decode
   localparam logic [6:0] SEXTET_INVALID = 7'd64;

   // Input beat
   typedef struct packed {
      logic [7:0] in_byte;
      logic       final_item;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_data;
      logic       run_last;
      logic       stream_end;
   } rsp_type;

   // Work for the back end: up to four result bytes of one input item
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
      logic            has_data;
      logic            stream_end;
   } job_type;

   // Queue status seen by the front end
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // Map a sextet to its output character
   function automatic logic [7:0] enc_char(input logic [5:0] v, input logic url);
      logic [7:0] ext;
      logic [7:0] c;
      ext = {2'b00, v};
      if (v < SEXTET_LOWER_BASE) begin
         c = CHR_UPPER_A + ext;
      end else if (v < SEXTET_DIGIT_BASE) begin
         c = CHR_LOWER_A + ext - {2'b00, SEXTET_LOWER_BASE};
      end else if (v < SEXTET_PLUS) begin
         c = CHR_DIGIT_0 + ext - {2'b00, SEXTET_DIGIT_BASE};
      end else if (v == SEXTET_PLUS) begin
         c = url ? CHR_MINUS : CHR_PLUS;
      end else begin
         c = url ? CHR_UNDER : CHR_SLASH;
      end
      return c;
   endfunction

   // Padding character of the selected alphabet
   function automatic logic [7:0] pad_char(input logic url);
      return url ? CHR_DOT : CHR_EQUALS;
   endfunction

   // Map a character to its sextet; bit 6 set means invalid
   function automatic logic [6:0] sextet(input logic [7:0] ch, input logic url);
      logic [7:0] c;
      logic [6:0] s;
      c = ch;
      if (url) begin
         if (c == CHR_MINUS) begin
            c = CHR_PLUS;
         end else if (c == CHR_UNDER) begin
            c = CHR_SLASH;
         end else if (c == CHR_DOT) begin
            c = CHR_EQUALS;
         end
      end
      if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
         s = 7'(c - CHR_UPPER_A);
      end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
         s = 7'(c - CHR_LOWER_A) + {1'b0, SEXTET_LOWER_BASE};
      end else if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
         s = 7'(c - CHR_DIGIT_0) + {1'b0, SEXTET_DIGIT_BASE};
      end else if (c == CHR_PLUS) begin
         s = {1'b0, SEXTET_PLUS};
      end else if (c == CHR_SLASH) begin
         s = {1'b0, SEXTET_SLASH};
      end else begin
         s = SEXTET_INVALID;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

/* hdl/b64_front.sv */
// Front end: configuration, group gathering and job building per input beat
`default_nettype none
module b64_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [1:0]             csr_index,
   input  wire logic                   csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire b64_pkg::req_type       req_beat,
   input  wire b64_pkg::fifo_stat_type fifo_stat,
   output logic                        push,
   output b64_pkg::job_type            push_job
);

   logic        dir_ff, dir_in;
   logic        url_ff, url_in;
   logic [23:0] bits_ff, bits_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        halt_ff, halt_in;

   logic        accept;
   logic        emit;
   logic [1:0]  pos;
   logic [1:0]  posn;
   logic [23:0] enc_bits;
   logic [6:0]  sx;
   logic [5:0]  v;
   logic        ok;
   logic [23:0] grp_bits;
   logic [1:0]  grp_cnt;
   logic        grp_halt;
   b64_pkg::job_type job;

   assign req_ready = !fifo_stat.full;
   assign accept    = req_valid && req_ready;

   assign sx = b64_pkg::sextet(req_beat.in_byte, url_ff);
   assign v  = sx[5:0];
   assign ok = !sx[6];

   // Build the job and the next group state for the offered beat
   always_comb begin
      emit     = 1'b0;
      grp_bits = bits_ff;
      grp_cnt  = cnt_ff;
      grp_halt = halt_ff;
      pos      = (cnt_ff == 2'd3) ? 2'd0 : cnt_ff;
      posn     = 2'd0;
      enc_bits = 24'd0;
      job      = '0;
      if (dir_ff == b64_pkg::DIR_ENCODE) begin
         // Merge the byte into its slot of the three-byte group
         case (pos)
            2'd0:    enc_bits = {req_beat.in_byte, 16'd0};
            2'd1:    enc_bits = bits_ff | {8'd0, req_beat.in_byte, 8'd0};
            default: enc_bits = bits_ff | {16'd0, req_beat.in_byte};
         endcase
         posn = pos + 2'd1;
         if (posn == 2'd3 || req_beat.final_item) begin
            emit          = 1'b1;
            job.data[0]   = b64_pkg::enc_char(enc_bits[23:18], url_ff);
            job.data[1]   = b64_pkg::enc_char(enc_bits[17:12], url_ff);
            job.data[2]   = (posn >= 2'd2) ? b64_pkg::enc_char(enc_bits[11:6], url_ff)
                                           : b64_pkg::pad_char(url_ff);
            job.data[3]   = (posn == 2'd3) ? b64_pkg::enc_char(enc_bits[5:0], url_ff)
                                           : b64_pkg::pad_char(url_ff);
            job.last_idx  = 2'd3;
            job.has_data  = 1'b1;
            grp_bits      = 24'd0;
            grp_cnt       = 2'd0;
         end else begin
            grp_bits = enc_bits;
            grp_cnt  = posn;
         end
      end else if (!halt_ff) begin
         case (cnt_ff)
            2'd0: begin
               if (!ok) begin
                  grp_halt = 1'b1;
               end else begin
                  grp_bits = {v, 18'd0};
                  grp_cnt  = 2'd1;
               end
            end
            2'd1: begin
               if (!ok) begin
                  grp_halt = 1'b1;
               end else begin
                  grp_bits = bits_ff | {6'd0, v, 12'd0};
                  grp_cnt  = 2'd2;
               end
            end
            2'd2: begin
               if (ok) begin
                  grp_bits = bits_ff | {12'd0, v, 5'd0, 1'b1};
               end
               grp_cnt = 2'd3;
            end
            default: begin
               // Full group: emit one to three bytes
               emit         = 1'b1;
               job.data[0]  = {bits_ff[23:18], bits_ff[17:16]};
               job.data[1]  = {bits_ff[15:12], bits_ff[11:8]};
               job.data[2]  = {bits_ff[7:6], v};
               job.last_idx = {1'b0, bits_ff[0]} + {1'b0, bits_ff[0] & ok};
               job.has_data = 1'b1;
               grp_bits     = 24'd0;
               grp_cnt      = 2'd0;
            end
         endcase
      end
      // Stream end: mark the last result, or make a bare marker
      if (req_beat.final_item) begin
         if (!emit) begin
            job.data     = '0;
            job.last_idx = 2'd0;
            job.has_data = 1'b0;
         end
         job.stream_end = 1'b1;
         grp_bits       = 24'd0;
         grp_cnt        = 2'd0;
         grp_halt       = 1'b0;
      end
   end

   assign push     = accept && (emit || req_beat.final_item);
   assign push_job = job;

   // Next state from configuration writes and accepted beats
   always_comb begin
      dir_in  = dir_ff;
      url_in  = url_ff;
      bits_in = bits_ff;
      cnt_in  = cnt_ff;
      halt_in = halt_ff;
      if (csr_we) begin
         unique case (csr_index)
            b64_pkg::CSR_DIRECTION: begin
               dir_in  = csr_wdata;
               bits_in = 24'd0;
               cnt_in  = 2'd0;
               halt_in = 1'b0;
            end
            b64_pkg::CSR_URL_SAFE: url_in = csr_wdata;
            default: ;
         endcase
      end else if (accept) begin
         bits_in = grp_bits;
         cnt_in  = grp_cnt;
         halt_in = grp_halt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff  <= b64_pkg::DIR_ENCODE;
         url_ff  <= 1'b0;
         bits_ff <= 24'd0;
         cnt_ff  <= 2'd0;
         halt_ff <= 1'b0;
      end else begin
         dir_ff  <= dir_in;
         url_ff  <= url_in;
         bits_ff <= bits_in;
         cnt_ff  <= cnt_in;
         halt_ff <= halt_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/b64_fifo.sv */
// Job queue between the front end and the back end
`default_nettype none
`include "base64_stream_codec_top_defines.svh"
module b64_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire b64_pkg::job_type push_job,
   input  wire logic             pop,
   output b64_pkg::job_type      head_job,
   output b64_pkg::fifo_stat_type stat
);

   localparam int PW = b64_pkg::FIFO_PTR_W;
   localparam int CW = b64_pkg::FIFO_CNT_W;
   localparam logic [PW-1:0] LAST_PTR = PW'(b64_pkg::FIFO_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(b64_pkg::FIFO_DEPTH);

   b64_pkg::job_type ent_ff [b64_pkg::FIFO_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == FULL_CNT);
   assign stat.empty = (cnt_ff == '0);
   assign head_job   = ent_ff[rd_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= push_job;
      end
   end

   `B64_ASSERT_ALWAYS(a_fifo_cnt_bound, clock, reset, cnt_ff <= FULL_CNT)
   `B64_ASSERT_IMPLY(a_fifo_no_overrun, clock, reset, push, !stat.full)

endmodule
`default_nettype wire

/* hdl/b64_back.sv */
// Back end: walk the bytes of the head job out as result beats
`default_nettype none
`include "base64_stream_codec_top_defines.svh"
module b64_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire b64_pkg::job_type head_job,
   input  wire logic             head_valid,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output b64_pkg::rsp_type      rsp_beat
);

   logic [1:0] idx_ff, idx_in;
   logic       last;

   assign last      = (idx_ff == head_job.last_idx);
   assign rsp_valid = head_valid;

   // Present the current byte of the head job
   always_comb begin
      rsp_beat.out_byte   = head_job.data[idx_ff];
      rsp_beat.has_data   = head_job.has_data;
      rsp_beat.run_last   = last;
      rsp_beat.stream_end = last && head_job.stream_end;
   end

   // Step to the next byte; drop the job after its last beat
   assign pop = rsp_valid && rsp_ready && last;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_valid && rsp_ready) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   `B64_ASSERT_IMPLY(a_back_idx_in_job, clock, reset, head_valid, idx_ff <= head_job.last_idx)
   `B64_ASSERT_IMPLY(a_back_idx_idle, clock, reset, !head_valid, idx_ff == 2'd0)

endmodule
`default_nettype wire

/* hdl/base64_stream_codec_top.sv */
// Top level of the streaming base64 encoder and decoder
// The front end takes one input beat per cycle while the two-entry job
// queue has room; the back end sends one result beat per cycle while
// rsp_ready is high. Encoding is paced by the back end at four result
// beats per three input bytes; decoding gives at most three bytes per
// four characters. Each job is registered in the queue before the back
// end presents it. Write the configuration registers only while the
// block is idle; a write to direction restarts the stream.
`default_nettype none
module base64_stream_codec_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic             csr_wdata,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire b64_pkg::req_type req_beat,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output b64_pkg::rsp_type      rsp_beat
);

   b64_pkg::fifo_stat_type fifo_stat;
   b64_pkg::job_type       push_job;
   b64_pkg::job_type       head_job;
   logic                   push;
   logic                   pop;

   b64_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .fifo_stat (fifo_stat),
      .push      (push),
      .push_job  (push_job)
   );

   b64_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (fifo_stat)
   );

   b64_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_valid (!fifo_stat.empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_beat   (rsp_beat)
   );

endmodule
`default_nettype wire

/* bench/tb_base64_stream_codec_top.sv */
// Testbench of the base64 stream codec: directed and random streams checked by a scoreboard
`timescale 1ns / 100ps

module tb_base64_stream_codec_top;

   typedef logic [7:0] octet_q_type[$];

   // Register indexes that the block does not decode
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   // Predicts result beats from accepted input beats and checks them in order
   class codec_scoreboard;
      logic                 dir;
      logic                 url;
      logic [23:0]          group;
      int unsigned          fill;
      bit                   halt;
      b64_pkg::rsp_type     awaited_out[$];
      int unsigned          errors;
      int unsigned          beats_in;
      int unsigned          beats_out;
      int unsigned          ignored;
      int unsigned          streams;

      function new();
         dir = b64_pkg::DIR_ENCODE;
         url = 1'b0;
         group = '0;
         fill = 0;
         halt = 1'b0;
         errors = 0;
         beats_in = 0;
         beats_out = 0;
         ignored = 0;
         streams = 0;
      endfunction

      // Character for a 6-bit value in the selected alphabet
      static function logic [7:0] value_char(input logic [5:0] v, input logic u);
         string      alpha;
         logic [7:0] c;
         alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
         c = alpha[v];
         if (u && c == b64_pkg::CHR_PLUS) begin
            c = b64_pkg::CHR_MINUS;
         end else if (u && c == b64_pkg::CHR_SLASH) begin
            c = b64_pkg::CHR_UNDER;
         end
         return c;
      endfunction

      static function logic [7:0] pad_symbol(input logic u);
         return u ? b64_pkg::CHR_DOT : b64_pkg::CHR_EQUALS;
      endfunction

      // Value of a character; ok drops for anything outside the alphabet
      static function logic [5:0] char_value(input logic [7:0] ch, input logic u,
                                             output bit ok);
         logic [7:0] c;
         c = ch;
         if (u) begin
            if (c == b64_pkg::CHR_MINUS) begin
               c = b64_pkg::CHR_PLUS;
            end else if (c == b64_pkg::CHR_UNDER) begin
               c = b64_pkg::CHR_SLASH;
            end else if (c == b64_pkg::CHR_DOT) begin
               c = b64_pkg::CHR_EQUALS;
            end
         end
         ok = 1'b1;
         for (int i = 0; i < 64; i++) begin
            if (value_char(6'(i), 1'b0) == c) begin
               return 6'(i);
            end
         end
         ok = 1'b0;
         return 6'd0;
      endfunction

      static function b64_pkg::rsp_type make_beat(input logic [7:0] b, input logic has);
         b64_pkg::rsp_type r;
         r.out_byte = b;
         r.has_data = has;
         r.run_last = 1'b0;
         r.stream_end = 1'b0;
         return r;
      endfunction

      function void write_reg(input logic [1:0] idx, input logic val);
         if (idx == b64_pkg::CSR_DIRECTION) begin
            dir = val;
            group = '0;
            fill = 0;
            halt = 1'b0;
         end else if (idx == b64_pkg::CSR_URL_SAFE) begin
            url = val;
         end
      endfunction

      // Work out the result beats that one input beat causes
      function void take_input(input b64_pkg::req_type b);
         b64_pkg::rsp_type burst[4];
         int               n;
         int               pos;
         logic [5:0]       v;
         bit               ok;
         n = 0;
         beats_in++;
         if (dir == b64_pkg::DIR_ENCODE) begin
            pos = (fill >= 3) ? 0 : fill;
            if (pos == 0) begin
               group = '0;
            end
            group = group | (24'(b.in_byte) << (16 - 8 * pos));
            pos++;
            if (pos == 3 || b.final_item) begin
               burst[0] = make_beat(value_char(group[23:18], url), 1'b1);
               burst[1] = make_beat(value_char(group[17:12], url), 1'b1);
               burst[2] = make_beat(pos >= 2 ? value_char(group[11:6], url) :
                                    pad_symbol(url), 1'b1);
               burst[3] = make_beat(pos == 3 ? value_char(group[5:0], url) :
                                    pad_symbol(url), 1'b1);
               n = 4;
               group = '0;
               fill = 0;
            end else begin
               fill = pos;
            end
         end else if (halt) begin
            if (!b.final_item) begin
               ignored++;
            end
         end else begin
            v = char_value(b.in_byte, url, ok);
            case (fill)
               0: begin
                  if (!ok) begin
                     halt = 1'b1;
                  end else begin
                     group = {v, 18'd0};
                     fill = 1;
                  end
               end
               1: begin
                  if (!ok) begin
                     halt = 1'b1;
                  end else begin
                     group[17:12] = v;
                     fill = 2;
                  end
               end
               2: begin
                  // Bit 0 remembers that the third character was valid
                  if (ok) begin
                     group[11:6] = v;
                     group[0] = 1'b1;
                  end
                  fill = 3;
               end
               default: begin
                  burst[0] = make_beat({group[23:18], group[17:16]}, 1'b1);
                  n = 1;
                  if (group[0]) begin
                     burst[1] = make_beat({group[15:12], group[11:8]}, 1'b1);
                     n = 2;
                     if (ok) begin
                        burst[2] = make_beat({group[7:6], v}, 1'b1);
                        n = 3;
                     end
                  end
                  group = '0;
                  fill = 0;
               end
            endcase
         end
         // Close the stream; a final beat with no data gives a bare end marker
         if (b.final_item) begin
            if (n == 0) begin
               burst[0] = make_beat(8'h00, 1'b0);
               n = 1;
            end
            group = '0;
            fill = 0;
            halt = 1'b0;
            burst[n - 1].stream_end = 1'b1;
            streams++;
         end
         if (n > 0) begin
            burst[n - 1].run_last = 1'b1;
         end
         for (int i = 0; i < n; i++) begin
            awaited_out.insert(awaited_out.size(), burst[i]);
         end
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_output(input b64_pkg::rsp_type got);
         b64_pkg::rsp_type want;
         beats_out++;
         if (awaited_out.size() == 0) begin
            $error("result beat with nothing awaited: out_byte %0h has_data %0b",
                   got.out_byte, got.has_data);
            errors++;
            return;
         end
         want = awaited_out.pop_front();
         compare_field("out_byte", want.out_byte, got.out_byte);
         compare_field("has_data", 8'(want.has_data), 8'(got.has_data));
         compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
         compare_field("stream_end", 8'(want.stream_end), 8'(got.stream_end));
      endfunction
   endclass

   logic             clock;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = b64_pkg::CSR_DIRECTION;
   logic             csr_wdata = 1'b0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   b64_pkg::req_type req_beat = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   b64_pkg::rsp_type rsp_beat;

   bit              idle_on = 1'b1;
   codec_scoreboard sb = new();

   base64_stream_codec_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Track both channels and the register port; stall the result side at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (csr_we) begin
            sb.write_reg(csr_index, csr_wdata);
         end
         if (req_valid && req_ready) begin
            sb.take_input(req_beat);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_output(rsp_beat);
         end
         rsp_ready <= !idle_on || ($urandom_range(99) >= 32);
      end
   end

   task automatic set_reg(input logic [1:0] idx, input logic val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one beat, with an optional random gap, and hold it until accepted
   task automatic send_beat(input logic [7:0] d, input logic fin);
      b64_pkg::req_type nb;
      if (idle_on && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < 32);
      end
      nb.in_byte = d;
      nb.final_item = fin;
      req_valid <= 1'b1;
      req_beat <= nb;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_stream(input octet_q_type items, input bit close);
      foreach (items[k]) begin
         send_beat(items[k], close && (k == items.size() - 1));
      end
   endtask

   // Drop valid and wait until every awaited beat is in, plus a short tail
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited_out.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   function automatic octet_q_type text_items(input string s);
      octet_q_type q;
      for (int i = 0; i < s.len(); i++) begin
         q.insert(q.size(), s[i]);
      end
      return q;
   endfunction

   // Encode raw bytes into padded text for well-formed decoder input
   function automatic octet_q_type pack_text(input octet_q_type raw, input logic u);
      octet_q_type txt;
      logic [23:0] g;
      int          left;
      for (int i = 0; i < raw.size(); i += 3) begin
         left = raw.size() - i;
         g = {raw[i], (left > 1) ? raw[i + 1] : 8'h00, (left > 2) ? raw[i + 2] : 8'h00};
         txt.insert(txt.size(), codec_scoreboard::value_char(g[23:18], u));
         txt.insert(txt.size(), codec_scoreboard::value_char(g[17:12], u));
         txt.insert(txt.size(), left > 1 ? codec_scoreboard::value_char(g[11:6], u) :
                                codec_scoreboard::pad_symbol(u));
         txt.insert(txt.size(), left > 2 ? codec_scoreboard::value_char(g[5:0], u) :
                                codec_scoreboard::pad_symbol(u));
      end
      return txt;
   endfunction

   task automatic random_byte_stream(input bit close);
      octet_q_type raw;
      repeat ($urandom_range(1, 8)) raw.insert(raw.size(), 8'($urandom_range(255)));
      send_stream(raw, close);
   endtask

   // Mostly well-formed text; the rest corrupted, cut short or plain noise
   task automatic random_text_stream(input logic u, input bit close);
      octet_q_type raw;
      octet_q_type txt;
      int          roll;
      int          pick;
      int          cut;
      roll = $urandom_range(99);
      if (roll < 85) begin
         repeat ($urandom_range(1, 7)) raw.insert(raw.size(), 8'($urandom_range(255)));
         txt = pack_text(raw, u);
         if (u && $urandom_range(3) == 0) begin
            foreach (txt[k]) begin
               if (txt[k] == b64_pkg::CHR_MINUS) begin
                  txt[k] = b64_pkg::CHR_PLUS;
               end else if (txt[k] == b64_pkg::CHR_UNDER) begin
                  txt[k] = b64_pkg::CHR_SLASH;
               end
            end
         end
         if (roll >= 70) begin
            txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(1)) begin
               cut = $urandom_range(1, txt.size());
               while (txt.size() > cut) begin
                  void'(txt.pop_back());
               end
            end
         end
      end else begin
         repeat ($urandom_range(1, 9)) begin
            pick = $urandom_range(3);
            if (pick < 2) begin
               txt.insert(txt.size(),
                          codec_scoreboard::value_char(6'($urandom_range(63)), u));
            end else if (pick == 2) begin
               txt.insert(txt.size(), codec_scoreboard::pad_symbol(u));
            end else begin
               txt.insert(txt.size(), 8'($urandom_range(255)));
            end
         end
      end
      send_stream(txt, close);
   endtask

   initial begin
      octet_q_type seq;
      int          phase;
      int          n_streams;
      logic        d;
      logic        u;
      logic        cur_dir;
      bit          close;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: full group, one- and two-byte padding, both alphabets
      set_reg(b64_pkg::CSR_DIRECTION, b64_pkg::DIR_ENCODE);
      set_reg(b64_pkg::CSR_URL_SAFE, 1'b0);
      set_reg(CSR_SPARE_LO, 1'b1);
      set_reg(CSR_SPARE_HI, 1'b1);
      seq = '{8'hFB, 8'hFF, 8'h00};
      send_stream(seq, 1'b1);
      seq = '{8'hFF};
      send_stream(seq, 1'b1);
      settle();
      set_reg(b64_pkg::CSR_URL_SAFE, 1'b1);
      seq = '{8'hFB, 8'hFF, 8'hBF, 8'h00, 8'hFF};
      send_stream(seq, 1'b1);

      // Directed decode: url-safe text, plus and slash kept valid in url mode
      settle();
      set_reg(b64_pkg::CSR_DIRECTION, b64_pkg::DIR_DECODE);
      send_stream(text_items("-_9."), 1'b1);
      send_stream(text_items("+/AB"), 1'b1);

      // Directed decode: early halt, invalid third character, dropped partial group
      settle();
      set_reg(b64_pkg::CSR_URL_SAFE, 1'b0);
      seq = '{8'hFF, b64_pkg::CHR_UPPER_A, 8'h00};
      send_stream(seq, 1'b1);
      send_stream(text_items("QU*A"), 1'b1);
      send_stream(text_items("QU"), 1'b1);
      cur_dir = b64_pkg::DIR_DECODE;

      // Random phases, each with its own setting; a few run with no idling
      phase = 0;
      while (sb.beats_in < 310) begin
         settle();
         idle_on = !(phase >= 5 && phase <= 7);
         if (phase < 4) begin
            d = phase[0];
            u = phase[1];
         end else begin
            d = 1'($urandom_range(1));
            u = 1'($urandom_range(1));
         end
         if ($urandom_range(3) == 0) begin
            set_reg($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                    1'($urandom_range(1)));
         end
         // Sometimes keep the direction so a url change lands mid-group
         if (phase >= 4 && d == cur_dir && $urandom_range(2) == 0) begin
            set_reg(b64_pkg::CSR_URL_SAFE, u);
         end else if ($urandom_range(1)) begin
            set_reg(b64_pkg::CSR_URL_SAFE, u);
            set_reg(b64_pkg::CSR_DIRECTION, d);
         end else begin
            set_reg(b64_pkg::CSR_DIRECTION, d);
            set_reg(b64_pkg::CSR_URL_SAFE, u);
         end
         cur_dir = d;
         n_streams = $urandom_range(2, 6);
         for (int s = 0; s < n_streams; s++) begin
            close = (s < n_streams - 1) || ($urandom_range(99) >= 15);
            if (d == b64_pkg::DIR_ENCODE) begin
               random_byte_stream(close);
            end else begin
               random_text_stream(u, close);
            end
         end
         phase++;
      end
      settle();

      if (sb.awaited_out.size() != 0) begin
         $error("%0d result beats never arrived", sb.awaited_out.size());
         sb.errors++;
      end
      $display("Checked %0d result beats from %0d input beats (%0d skipped while halted)",
               sb.beats_out, sb.beats_in, sb.ignored);
      $display("over %0d closed streams, encoding and decoding in both alphabets.",
               sb.streams);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Hard stop for a hung handshake
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
